// ===== design/capsule_distance_core_assert.svh =====
// Assertion helpers for the capsule distance core
`ifndef CAPSULE_DISTANCE_CORE_ASSERT_SVH
`define CAPSULE_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define CAPDIST_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAPDIST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/capdist_pkg.sv =====
// ----------------------------------------------------------------------------
// capdist_pkg
// Shared constants and types of the capsule distance core.
// ----------------------------------------------------------------------------
package capdist_pkg;

   localparam int CAPDIST_FRAC_DEFAULT = 16;
   localparam int CAPDIST_COORD_W      = 32;
   localparam int CAPDIST_RADIUS_W     = 31;
   localparam int CAPDIST_CSR_IDX_W    = 3;
   localparam int CAPDIST_ROOT_W       = 33;

   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_END_A_X = 3'd0;
   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_END_A_Y = 3'd1;
   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_END_A_Z = 3'd2;
   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_END_B_X = 3'd3;
   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_END_B_Y = 3'd4;
   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_END_B_Z = 3'd5;
   localparam logic [CAPDIST_CSR_IDX_W-1:0] CSR_RADIUS  = 3'd6;

   typedef struct packed {
      logic              one;
      logic              zero;
      logic [2:0][31:0]  a;
      logic [2:0][32:0]  ab;
      logic [2:0][31:0]  p;
   } capdist_side_type;

endpackage

// ===== design/capdist_div.sv =====
// ----------------------------------------------------------------------------
// capdist_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module capdist_div
   import capdist_pkg::*;
#(
   parameter int FRAC   = CAPDIST_FRAC_DEFAULT,
   parameter int DW     = 67,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [DW-1:0]     in_num,
   input  logic [DW-1:0]     in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [FRAC-1:0]   out_q,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [FRAC];
   logic [DW-1:0]     r_ff    [FRAC];
   logic [DW-1:0]     den_ff  [FRAC];
   logic [FRAC-1:0]   q_ff    [FRAC];
   logic [SIDE_W-1:0] side_ff [FRAC];

   for (genvar k = 0; k < FRAC; k++) begin : g_stage
      logic              vld_prev;
      logic [DW-1:0]     r_prev;
      logic [DW-1:0]     den_prev;
      logic [FRAC-1:0]   q_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DW:0]       r2;
      logic              ge;
      logic [DW-1:0]     r_in;
      logic [FRAC-1:0]   q_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign r_prev    = in_num;
         assign den_prev  = in_den;
         assign q_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_rest
         assign vld_prev  = vld_ff[k-1];
         assign r_prev    = r_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign q_prev    = q_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      always_comb begin
         r2   = {r_prev, 1'b0};
         ge   = (r2 >= {1'b0, den_prev});
         r_in = ge ? DW'(r2 - {1'b0, den_prev}) : r2[DW-1:0];
         q_in = {q_prev[FRAC-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[k]    <= r_in;
            den_ff[k]  <= den_prev;
            q_ff[k]    <= q_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[FRAC-1];
   assign out_q     = q_ff[FRAC-1];
   assign out_side  = side_ff[FRAC-1];

endmodule

// ===== design/capdist_sqrt.sv =====
// ----------------------------------------------------------------------------
// capdist_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module capdist_sqrt
   import capdist_pkg::*;
#(
   parameter int RW = CAPDIST_ROOT_W
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_n,
   output logic            out_valid,
   output logic [RW-1:0]   out_root
);

   localparam int TW = 2*RW + 2;

   logic            vld_ff  [RW];
   logic [2*RW-1:0] rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int BIT = RW - 1 - k;
      logic            vld_prev;
      logic [2*RW-1:0] rem_prev;
      logic [RW-1:0]   root_prev;
      logic [TW-1:0]   trial;
      logic            ge;
      logic [2*RW-1:0] rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = in_n;
         assign root_prev = '0;
      end else begin : g_rest
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         trial   = (TW'(root_prev) << (BIT + 1)) | (TW'(1) << (2 * BIT));
         ge      = (TW'(rem_prev) >= trial);
         rem_in  = ge ? (2*RW)'(TW'(rem_prev) - trial) : rem_prev;
         root_in = root_prev | (ge ? (RW'(1) << BIT) : '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];

endmodule

// ===== design/capsule_distance_core.sv =====
// ----------------------------------------------------------------------------
// capsule_distance_core
// Signed distance from a query point to a capsule (segment plus radius).
//
//   channel | ports              | carries
//   --------+--------------------+------------------------------------------
//   request | req_t*             | point x, y, z (Q16.16)
//   result  | rsp_t*             | distance (tdata), saturated flag (tuser)
//   config  | csr_we/index/wdata | endpoints A, B and radius
//
// One request per cycle while the result is not stalled; the pipe includes the
// divider (one stage per fraction bit) and the square root (33 stages).
// All stages advance together; a stalled result freezes the whole pipe.
// Reset clears the valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module capsule_distance_core
   import capdist_pkg::*;
#(
   parameter int FRACTION_BITS = CAPDIST_FRAC_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [95:0]                  req_tdata,   // point_x, point_y, point_z
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,   // distance
   output logic [0:0]                   rsp_tuser,   // saturated
   input  logic                         csr_we,
   input  logic [CAPDIST_CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                  csr_wdata
);

   localparam int DW     = 67;
   localparam int PW     = 35 + FRACTION_BITS;
   localparam int SIDE_W = $bits(capdist_side_type);

   logic [2:0][31:0] end_a_ff, end_b_ff;
   logic [CAPDIST_RADIUS_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_a_ff  <= '0;
         end_b_ff  <= '0;
         radius_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_END_A_X: end_a_ff[0] <= csr_wdata;
            CSR_END_A_Y: end_a_ff[1] <= csr_wdata;
            CSR_END_A_Z: end_a_ff[2] <= csr_wdata;
            CSR_END_B_X: end_b_ff[0] <= csr_wdata;
            CSR_END_B_Y: end_b_ff[1] <= csr_wdata;
            CSR_END_B_Z: end_b_ff[2] <= csr_wdata;
            CSR_RADIUS:  radius_ff   <= csr_wdata[CAPDIST_RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   logic [31:0] rsp_dist_ff;
   logic rsp_sat_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: differences
   logic v1_ff;
   logic [2:0][31:0] a1_ff, p1_ff;
   logic [2:0][32:0] ab1_ff, ap1_ff;
   logic [2:0][32:0] ab1_in, ap1_in;
   logic [2:0][31:0] p1_in;

   always_comb begin
      p1_in = req_tdata;
      for (int i = 0; i < 3; i++) begin
         ab1_in[i] = {end_b_ff[i][31], end_b_ff[i]} - {end_a_ff[i][31], end_a_ff[i]};
         ap1_in[i] = {p1_in[i][31], p1_in[i]} - {end_a_ff[i][31], end_a_ff[i]};
      end
   end

   // stage 2: products
   logic v2_ff;
   logic [2:0][31:0] a2_ff, p2_ff;
   logic [2:0][32:0] ab2_ff;
   logic signed [65:0] pn2_ff [3];
   logic signed [65:0] pd2_ff [3];

   // stage 3: dot products
   logic v3_ff;
   logic [2:0][31:0] a3_ff, p3_ff;
   logic [2:0][32:0] ab3_ff;
   logic signed [67:0] num3_ff, den3_ff;

   // stage 4: clamp decision
   logic v4_ff;
   capdist_side_type side4_ff, side4_in;
   logic [DW-1:0] r4_ff, d4_ff;

   always_comb begin
      side4_in.zero = (den3_ff == '0) || (num3_ff <= 68'sd0);
      side4_in.one  = !side4_in.zero && (num3_ff >= den3_ff);
      side4_in.a    = a3_ff;
      side4_in.ab   = ab3_ff;
      side4_in.p    = p3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= end_a_ff;
         p1_ff  <= p1_in;
         ab1_ff <= ab1_in;
         ap1_ff <= ap1_in;
         a2_ff  <= a1_ff;
         p2_ff  <= p1_ff;
         ab2_ff <= ab1_ff;
         for (int i = 0; i < 3; i++) begin
            pn2_ff[i] <= $signed(ab1_ff[i]) * $signed(ap1_ff[i]);
            pd2_ff[i] <= $signed(ab1_ff[i]) * $signed(ab1_ff[i]);
         end
         a3_ff    <= a2_ff;
         p3_ff    <= p2_ff;
         ab3_ff   <= ab2_ff;
         num3_ff  <= 68'(pn2_ff[0]) + 68'(pn2_ff[1]) + 68'(pn2_ff[2]);
         den3_ff  <= 68'(pd2_ff[0]) + 68'(pd2_ff[1]) + 68'(pd2_ff[2]);
         side4_ff <= side4_in;
         r4_ff    <= num3_ff[DW-1:0];
         d4_ff    <= den3_ff[DW-1:0];
      end
   end

   logic div_valid;
   logic [FRACTION_BITS-1:0] div_q;
   logic [SIDE_W-1:0] div_side_raw;
   capdist_side_type div_side;

   capdist_div #(
      .FRAC   (FRACTION_BITS),
      .DW     (DW),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_num    (r4_ff),
      .in_den    (d4_ff),
      .in_side   (side4_ff),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_side  (div_side_raw)
   );

   assign div_side = capdist_side_type'(div_side_raw);

   // stage 5: scale segment by t
   logic [FRACTION_BITS:0] tq5_in;
   logic v5_ff;
   logic [2:0][31:0] a5_ff, p5_ff;
   logic signed [PW-1:0] prod5_ff [3];

   always_comb begin
      if (div_side.zero) begin
         tq5_in = '0;
      end else if (div_side.one) begin
         tq5_in = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
      end else begin
         tq5_in = {1'b0, div_q};
      end
   end

   // stage 6: offset magnitudes
   logic v6_ff;
   logic [2:0][31:0] mag6_ff, mag6_in;
   logic signed [PW-1:0] sh6;
   logic signed [33:0] c6, d6;

   always_comb begin
      sh6 = '0;
      c6  = '0;
      d6  = '0;
      for (int i = 0; i < 3; i++) begin
         sh6 = prod5_ff[i] >>> FRACTION_BITS;
         c6  = $signed({{2{a5_ff[i][31]}}, a5_ff[i]}) + $signed(sh6[33:0]);
         d6  = $signed({{2{p5_ff[i][31]}}, p5_ff[i]}) - c6;
         mag6_in[i] = d6[33] ? 32'(-d6) : d6[31:0];
      end
   end

   // stage 7: squares; stage 8: sum
   logic v7_ff, v8_ff;
   logic [63:0] sq7_ff [3];
   logic [2*CAPDIST_ROOT_W-1:0] sum8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= div_valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a5_ff <= div_side.a;
         p5_ff <= div_side.p;
         for (int i = 0; i < 3; i++) begin
            prod5_ff[i] <= $signed(div_side.ab[i]) * $signed({1'b0, tq5_in});
            sq7_ff[i]   <= mag6_ff[i] * mag6_ff[i];
         end
         mag6_ff <= mag6_in;
         sum8_ff <= (2*CAPDIST_ROOT_W)'(sq7_ff[0]) + (2*CAPDIST_ROOT_W)'(sq7_ff[1])
                    + (2*CAPDIST_ROOT_W)'(sq7_ff[2]);
      end
   end

   logic sqrt_valid;
   logic [CAPDIST_ROOT_W-1:0] sqrt_root;

   capdist_sqrt #(
      .RW (CAPDIST_ROOT_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .in_n      (sum8_ff),
      .out_valid (sqrt_valid),
      .out_root  (sqrt_root)
   );

   // output: subtract radius, saturate high
   logic signed [33:0] res_in;
   logic sat_in;

   always_comb begin
      res_in = $signed({1'b0, sqrt_root}) - $signed({3'b000, radius_ff});
      sat_in = !res_in[33] && (res_in[32:31] != 2'b00);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sqrt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_dist_ff <= sat_in ? 32'h7FFF_FFFF : res_in[31:0];
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_dist_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

   logic rsp_stall;
   logic rsp_sat_out;

   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_sat_out = rsp_tvalid && rsp_tuser[0];

`include "capsule_distance_core_assert.svh"

   `CAPDIST_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "rsp held")
   `CAPDIST_ASSERT_IMPL(a_sat, clock, reset, rsp_sat_out, rsp_tdata == 32'h7FFF_FFFF, "bad sat")
   `CAPDIST_ASSERT_IMPL(a_ready, clock, reset, !rsp_tvalid, req_tready, "ready low when empty")
endmodule
